### sv/itf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itf_pkg: shared types and constants
// Item formats, the classified work descriptor, back-end states and the
// ASCII constants used by the integer-to-text formatter.
// ----------------------------------------------------------------------------
package itf_pkg;

  localparam int DIGIT_SLOTS = 11;
  localparam int DIGIT_IDX_W = $clog2(DIGIT_SLOTS);
  localparam int DIGIT_CNT_W = $clog2(DIGIT_SLOTS + 1);

  localparam int Q_DEPTH = 2;

  // format_flags bit positions
  localparam int FL_LEFT   = 0;
  localparam int FL_PLUS   = 1;
  localparam int FL_SIGNED = 2;
  localparam int FL_PREFIX = 3;
  localparam int FL_ZERO   = 4;
  localparam int FL_LOWER  = 5;

  // mode codes
  localparam logic [1:0] MODE_DEC = 2'd0;
  localparam logic [1:0] MODE_OCT = 2'd1;

  // divide by 10: q = (x * DEC_RECIP) >> DEC_SHIFT, exact for 32-bit x
  localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
  localparam int          DEC_SHIFT = 35;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  typedef enum logic [1:0] {
    RDX_DEC,
    RDX_OCT,
    RDX_HEX
  } radix_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_PLAN,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  mode;
    logic [6:0]  min_width;
    logic [5:0]  format_flags;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_item_t;

  typedef struct packed {
    logic [31:0] mag;
    radix_t      radix;
    logic        has_sign;
    logic        minus;
    logic [1:0]  prefix_len;
    logic [6:0]  width;
    logic        left;
    logic        zero;
    logic        lower;
  } desc_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
    logic [7:0] base;
    base = lower ? CH_A_LO : CH_A_UP;
    if (d < 4'd10) begin
      return CH_ZERO + {4'd0, d};
    end
    return base + {4'd0, d} - 8'd10;
  endfunction

endpackage
`default_nettype wire

### sv/itf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itf_front: item intake and classification
// Takes input items, resolves sign, magnitude, radix, prefix and the
// saturated field width, and holds the descriptor until the queue takes it.
// ----------------------------------------------------------------------------
module itf_front #(
  parameter int MAX_WIDTH = 64
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  itf_pkg::in_item_t in_item,
  output logic              push_valid,
  input  wire               push_ready,
  output itf_pkg::desc_t    push_desc
);
  import itf_pkg::*;

  desc_t  cls;
  logic   neg;
  logic   in_go;

  assign in_ready = !push_valid || push_ready;
  assign in_go    = in_valid && in_ready;

  always_comb begin
    cls = '0;
    neg = (in_item.format_flags[FL_SIGNED] || in_item.format_flags[FL_PLUS]) &&
          in_item.value[31];
    unique case (in_item.mode)
      MODE_DEC: cls.radix = RDX_DEC;
      MODE_OCT: cls.radix = RDX_OCT;
      default:  cls.radix = RDX_HEX;   // modes 2 and 3 print as hex
    endcase
    cls.mag      = neg ? (~in_item.value + 32'd1) : in_item.value;
    cls.minus    = neg;
    cls.has_sign = neg || in_item.format_flags[FL_PLUS];
    if (in_item.format_flags[FL_PREFIX]) begin
      cls.prefix_len = (cls.radix == RDX_OCT) ? 2'd1 :
                       (cls.radix == RDX_HEX) ? 2'd2 : 2'd0;
    end
    cls.width = (in_item.min_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH)
                                                    : in_item.min_width;
    cls.left  = in_item.format_flags[FL_LEFT];
    cls.zero  = in_item.format_flags[FL_ZERO];
    cls.lower = in_item.format_flags[FL_LOWER];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push_valid <= 1'b0;
    end else if (in_go) begin
      push_valid <= 1'b1;
    end else if (push_ready) begin
      push_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      push_desc <= cls;
    end
  end

endmodule
`default_nettype wire

### sv/itf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itf_queue: descriptor queue
// Short register FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module itf_queue (
  input  wire            clk,
  input  wire            rst,
  input  wire            push_valid,
  output logic           push_ready,
  input  itf_pkg::desc_t push_desc,
  output logic           pop_valid,
  input  wire            pop_ready,
  output itf_pkg::desc_t pop_desc
);
  import itf_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  desc_t              slots [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push_go;
  logic               pop_go;

  assign push_ready = (count != CNT_W'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign push_go    = push_valid && push_ready;
  assign pop_go     = pop_valid && pop_ready;
  assign pop_desc   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_go) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_go) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_go && !pop_go) begin
        count <= count + 1'b1;
      end else if (pop_go && !push_go) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_go) begin
      slots[wr_ptr] <= push_desc;
    end
  end

endmodule
`default_nettype wire

### sv/itf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itf_back: digit conversion and character emission
// Splits the magnitude into digits (one per cycle for octal/hex; a multiply
// then remainder for decimal), lays out, streams one char per cycle unstalled.
// ----------------------------------------------------------------------------
module itf_back (
  input  wire                clk,
  input  wire                rst,
  input  wire                pop_valid,
  output logic               pop_ready,
  input  itf_pkg::desc_t     pop_desc,
  output logic               out_valid,
  input  wire                out_ready,
  output itf_pkg::out_item_t out_item
);
  import itf_pkg::*;

  bk_state_t              state;
  bk_state_t              state_next;
  desc_t                  cur;
  logic [31:0]            quot;
  logic [63:0]            prod;
  logic [DIGIT_CNT_W-1:0] dcount;
  logic [3:0]             digit_store [DIGIT_SLOTS];
  logic [6:0]             b1, b2, b3, b4, b5, total;
  logic [6:0]             k;

  logic                   pop_go;
  logic                   emit_go;
  logic [31:0]            q;
  logic [31:0]            q_dec;
  logic [3:0]             rem;
  logic                   conv_done;
  logic [6:0]             body, pad, lead, zeros, trail;
  logic [6:0]             p1, p2, p3, p4, p5, ptot;
  logic [6:0]             didx;
  logic [7:0]             ch;
  logic                   is_last;

  // ---- digit step
  assign q_dec = 32'(prod >> DEC_SHIFT);

  always_comb begin
    unique case (cur.radix)
      RDX_DEC: begin
        q   = q_dec;
        rem = quot[3:0] - ({q_dec[0], 3'b000} + {q_dec[2:0], 1'b0});
      end
      RDX_OCT: begin
        q   = {3'd0, quot[31:3]};
        rem = {1'b0, quot[2:0]};
      end
      RDX_HEX: begin
        q   = {4'd0, quot[31:4]};
        rem = quot[3:0];
      end
      default: begin
        q   = '0;
        rem = '0;
      end
    endcase
  end

  assign conv_done = (q == '0) || (dcount + 1'b1 == DIGIT_CNT_W'(DIGIT_SLOTS));

  // ---- field layout: region boundaries along the output text
  always_comb begin
    body  = 7'(cur.has_sign) + 7'(cur.prefix_len) + 7'(dcount);
    pad   = (cur.width > body) ? cur.width - body : 7'd0;
    lead  = (!cur.left && !cur.zero) ? pad : 7'd0;
    zeros = (!cur.left && cur.zero) ? pad : 7'd0;
    trail = cur.left ? pad : 7'd0;
    p1    = lead;
    p2    = p1 + 7'(cur.has_sign);
    p3    = p2 + 7'(cur.prefix_len);
    p4    = p3 + zeros;
    p5    = p4 + 7'(dcount);
    ptot  = p5 + trail;
  end

  // ---- character at position k
  assign didx    = b5 - 7'd1 - k;
  assign is_last = (k == total - 7'd1);

  always_comb begin
    if (k < b1) begin
      ch = CH_SPACE;
    end else if (k < b2) begin
      ch = cur.minus ? CH_MINUS : CH_PLUS;
    end else if (k < b3) begin
      ch = (k == b2) ? CH_ZERO : (cur.lower ? CH_X_LO : CH_X_UP);
    end else if (k < b4) begin
      ch = CH_ZERO;
    end else if (k < b5) begin
      ch = digit_char(digit_store[didx[DIGIT_IDX_W-1:0]], cur.lower);
    end else begin
      ch = CH_SPACE;
    end
  end

  // ---- control outputs
  always_comb begin
    pop_ready = (state == BK_IDLE);
    pop_go    = pop_ready && pop_valid;
    emit_go   = (state == BK_EMIT) && (!out_valid || out_ready);
  end

  // ---- next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (pop_valid) begin
          state_next = (pop_desc.radix == RDX_DEC) ? BK_MUL : BK_DIV;
        end
      end
      BK_MUL:  state_next = BK_DIV;
      BK_DIV: begin
        if (conv_done) begin
          state_next = BK_PLAN;
        end else begin
          state_next = (cur.radix == RDX_DEC) ? BK_MUL : BK_DIV;
        end
      end
      BK_PLAN: state_next = BK_EMIT;
      BK_EMIT: begin
        if (emit_go && is_last) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_go) begin
      cur    <= pop_desc;
      quot   <= pop_desc.mag;
      dcount <= '0;
    end
    if (state == BK_MUL) begin
      prod <= {32'd0, quot} * {32'd0, DEC_RECIP};
    end
    if (state == BK_DIV) begin
      digit_store[dcount[DIGIT_IDX_W-1:0]] <= rem;
      dcount <= dcount + 1'b1;
      quot   <= q;
    end
    if (state == BK_PLAN) begin
      b1    <= p1;
      b2    <= p2;
      b3    <= p3;
      b4    <= p4;
      b5    <= p5;
      total <= ptot;
      k     <= '0;
    end
    if (emit_go) begin
      out_item.out_char  <= ch;
      out_item.last_char <= is_last;
      k                  <= k + 7'd1;
    end
  end

endmodule
`default_nettype wire

### sv/integer_to_text_formatter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_text_formatter: printf-style integer to ASCII text
// Formats a 32-bit value in octal, decimal or hex with sign, radix prefix,
// field-width padding and case control, one character per output item.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+---------------------------------
//  in      | in  | in_valid / in_ready   | in_item: value, mode,
//          |     |                       |   min_width, format_flags
//  out     | out | out_valid / out_ready | out_item: out_char, last_char
//
// Flow: the front end classifies an item into a registered descriptor and
//   parks it in a two-entry queue. The back end picks it up in BK_IDLE, then
//   takes digits in BK_DIV, each decimal digit preceded by BK_MUL (the
//   reciprocal multiply is registered before the remainder step), lays out
//   the field in BK_PLAN and emits one character per cycle in BK_EMIT while
//   the output is not stalled.
// Reset: rst clears the handshake and sequencing state only.
// Stalls: out_ready low freezes emission; the front keeps accepting until
//   its holding register and the queue are full.
//
module integer_to_text_formatter #(
  parameter int MAX_WIDTH = 64
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  itf_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  wire                out_ready,
  output itf_pkg::out_item_t out_item
);
  import itf_pkg::*;

  // front -> queue
  logic  push_valid;
  logic  push_ready;
  desc_t push_desc;

  // queue -> back
  logic  pop_valid;
  logic  pop_ready;
  desc_t pop_desc;

  // intake: sign/magnitude, radix decode, width saturation
  itf_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc)
  );

  // decouples intake from the long conversion/emission loop
  itf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_desc   (pop_desc)
  );

  // digit generation, field layout and the registered output stage
  itf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_desc  (pop_desc),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // ---- checks
  // Items inside the block: front register, two queue slots, the one in
  // conversion and a finished last char still in the output register.
  logic [2:0] items_open;
  logic       in_go;
  logic       last_go;

  assign in_go   = in_valid && in_ready;
  assign last_go = out_valid && out_ready && out_item.last_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      items_open <= '0;
    end else if (in_go && !last_go) begin
      items_open <= items_open + 3'd1;
    end else if (last_go && !in_go) begin
      items_open <= items_open - 3'd1;
    end
  end

  a_open_bound: assert property (@(posedge clk) disable iff (rst)
    items_open <= 3'd5)
    else $error("more items in flight than storage allows");

  a_no_orphan_last: assert property (@(posedge clk) disable iff (rst)
    last_go |-> (items_open != 3'd0))
    else $error("final char delivered with no item outstanding");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (push_valid && !push_ready))
    else $error("intake stalled while the queue could take the descriptor");

  a_busy_output: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && !out_item.last_char) |=> out_valid)
    else $error("output dropped in the middle of a text");

endmodule
`default_nettype wire
